>>> rtl/rcf_pkg.sv
// Shared types and constants of the RGB 5x5 convolution filter.
package rcf_pkg;

  localparam int KSIZE      = 5;
  localparam int HALF_K     = (KSIZE - 1) / 2;
  localparam int LINES      = KSIZE - 1;
  localparam int COEF_W     = 12;
  localparam int CHAN_W     = 8;
  localparam int NCHAN      = 3;
  localparam int PIX_W      = NCHAN * CHAN_W;
  localparam int ROW_W      = 12;
  localparam int SHIFT_W    = 4;
  localparam int BIAS_W     = 9;
  localparam int FSIZE_W    = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = KSIZE * COEF_W;
  localparam int MIN_DIM    = KSIZE;
  localparam int PROD_W     = COEF_W + CHAN_W + 1;
  localparam int RSUM_W     = PROD_W + 3;
  localparam int ACC_W      = 28;

  localparam logic [FSIZE_W-1:0] FRAME_SIZE_RST = 24'd1966720;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF0 = 4'd0,
    REG_COEF1 = 4'd1,
    REG_COEF2 = 4'd2,
    REG_COEF3 = 4'd3,
    REG_COEF4 = 4'd4,
    REG_SHIFT = 4'd5,
    REG_BIAS  = 4'd6,
    REG_FRAME = 4'd7
  } cfg_reg_e;

  typedef logic [KSIZE-1:0] mask_t;

  // per-word control passed from front to back
  typedef struct packed {
    logic  emit;
    logic  last;
    mask_t rmask;
    mask_t cmask;
  } tag_t;

endpackage

>>> rtl/rcf_if.sv
// Stream and configuration channel interfaces of the RGB 5x5 filter.
interface rcf_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rcf_pkg::CHAN_W-1:0]  chan0;
  logic [rcf_pkg::CHAN_W-1:0]  chan1;
  logic [rcf_pkg::CHAN_W-1:0]  chan2;
  modport source (output valid, req_type, chan0, chan1, chan2, input ready);
  modport sink   (input valid, req_type, chan0, chan1, chan2, output ready);
endinterface

interface rcf_res_if;
  logic                        valid;
  logic                        ready;
  logic [rcf_pkg::CHAN_W-1:0]  out_chan0;
  logic [rcf_pkg::CHAN_W-1:0]  out_chan1;
  logic [rcf_pkg::CHAN_W-1:0]  out_chan2;
  logic                        frame_last;
  modport source (output valid, out_chan0, out_chan1, out_chan2, frame_last, input ready);
  modport sink   (input valid, out_chan0, out_chan1, out_chan2, frame_last, output ready);
endinterface

interface rcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rcf_pkg::CFG_IDX_W-1:0]  index;
  logic [rcf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rcf_front.sv
// Input side: frame position tracking and classification of each word.
module rcf_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rcf_pkg::FSIZE_W-1:0]  frame_size_i,
  rcf_pix_if.sink                      pix_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [CW-1:0]                col_o,
  output logic [rcf_pkg::PIX_W-1:0]    sample_o,
  output rcf_pkg::tag_t                tag_o
);

  localparam int RW = rcf_pkg::ROW_W;

  logic              open_q;
  logic [WW-1:0]     w_q, w_cur, fs_w, wm1;
  logic [RW-1:0]     h_q, h_cur, fs_h;
  logic [CW-1:0]     icol_q, ocol_q;
  logic [RW:0]       irow_q;
  logic [RW-1:0]     orow_q;
  logic [RW-1:0]     raw_w, raw_h;
  logic              accept, emit, icol_last, ocol_last, out_last;
  logic [WW:0]       ocx, wx;
  logic [RW:0]       orx, hx;

  assign raw_w = frame_size_i[RW-1:0];
  assign raw_h = frame_size_i[2*RW-1:RW];

  always_comb begin
    if (raw_w < RW'(rcf_pkg::MIN_DIM)) begin
      fs_w = WW'(rcf_pkg::MIN_DIM);
    end else if ((RW+1)'(raw_w) > (RW+1)'(MAX_WIDTH)) begin
      fs_w = WW'(MAX_WIDTH);
    end else begin
      fs_w = WW'(raw_w);
    end
    if (raw_h < RW'(rcf_pkg::MIN_DIM)) begin
      fs_h = RW'(rcf_pkg::MIN_DIM);
    end else begin
      fs_h = raw_h;
    end
  end

  // size is taken from the register on the first word of a frame
  assign w_cur = open_q ? w_q : fs_w;
  assign h_cur = open_q ? h_q : fs_h;
  assign wm1   = w_cur - WW'(1);

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && !full_i;

  assign emit = (irow_q > (RW+1)'(rcf_pkg::HALF_K)) ||
                ((irow_q == (RW+1)'(rcf_pkg::HALF_K)) && (icol_q >= CW'(rcf_pkg::HALF_K)));

  assign icol_last = (icol_q == CW'(wm1));
  assign ocol_last = (ocol_q == CW'(wm1));
  assign out_last  = ocol_last && (orow_q == h_cur - RW'(1));

  assign ocx = (WW+1)'(ocol_q);
  assign wx  = (WW+1)'(w_cur);
  assign orx = (RW+1)'(orow_q);
  assign hx  = (RW+1)'(h_cur);

  always_comb begin
    tag_o.emit     = emit;
    tag_o.last     = out_last;
    tag_o.rmask[0] = orow_q >= RW'(2);
    tag_o.rmask[1] = orow_q >= RW'(1);
    tag_o.rmask[2] = 1'b1;
    tag_o.rmask[3] = (orx + (RW+1)'(1)) < hx;
    tag_o.rmask[4] = (orx + (RW+1)'(2)) < hx;
    tag_o.cmask[0] = ocol_q >= CW'(2);
    tag_o.cmask[1] = ocol_q >= CW'(1);
    tag_o.cmask[2] = 1'b1;
    tag_o.cmask[3] = (ocx + (WW+1)'(1)) < wx;
    tag_o.cmask[4] = (ocx + (WW+1)'(2)) < wx;
  end

  assign push_o   = accept;
  assign col_o    = icol_q;
  assign sample_o = pix_i.req_type ? '0 : {pix_i.chan2, pix_i.chan1, pix_i.chan0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      w_q    <= WW'(640);
      h_q    <= RW'(480);
      icol_q <= '0;
      irow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (accept) begin
      open_q <= 1'b1;
      w_q    <= w_cur;
      h_q    <= h_cur;
      if (emit && out_last) begin
        open_q <= 1'b0;
        icol_q <= '0;
        irow_q <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (icol_last) begin
          icol_q <= '0;
          irow_q <= irow_q + (RW+1)'(1);
        end else begin
          icol_q <= icol_q + CW'(1);
        end
        if (emit) begin
          if (ocol_last) begin
            ocol_q <= '0;
            orow_q <= orow_q + RW'(1);
          end else begin
            ocol_q <= ocol_q + CW'(1);
          end
        end
      end
    end
  end

endmodule

>>> rtl/rcf_fifo.sv
// Small word queue between the front and back parts.
module rcf_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + AW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + (AW+1)'(1))
    else $error("queue count did not grow on push");

endmodule

>>> rtl/rcf_back.sv
// Back part: line buffers, 5x5 window, multiply-add pipeline, rounding and saturation.
module rcf_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [rcf_pkg::KSIZE-1:0][rcf_pkg::CFG_DATA_W-1:0] coef_i,
  input  logic [rcf_pkg::SHIFT_W-1:0]                       shift_i,
  input  logic signed [rcf_pkg::BIAS_W-1:0]                 bias_i,
  input  logic                                              empty_i,
  output logic                                              pop_o,
  input  logic [CW-1:0]                                     col_i,
  input  logic [rcf_pkg::PIX_W-1:0]                         sample_i,
  input  rcf_pkg::tag_t                                     tag_i,
  rcf_res_if.source                                         res_o
);

  localparam int K   = rcf_pkg::KSIZE;
  localparam int NL  = rcf_pkg::LINES;
  localparam int PW  = rcf_pkg::PIX_W;
  localparam int CHW = rcf_pkg::CHAN_W;
  localparam int NC  = rcf_pkg::NCHAN;
  localparam int CFW = rcf_pkg::COEF_W;
  localparam int PRW = rcf_pkg::PROD_W;
  localparam int RSW = rcf_pkg::RSUM_W;
  localparam int AW  = rcf_pkg::ACC_W;

  logic en;

  // line store: one row per column, older lines in higher bits
  logic [NL*PW-1:0] lbuf_q [MAX_WIDTH];
  logic [NL*PW-1:0] rd_q;

  logic                  s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, ov_q;
  logic [CW-1:0]         s0_col_q;
  logic [PW-1:0]         s0_pix_q;
  rcf_pkg::tag_t         s0_tag_q, s1_tag_q, s2_tag_q, s3_tag_q;
  logic [PW-1:0]         win_q [K][K];
  logic signed [PRW-1:0] prod_q [NC][K][K];
  logic signed [RSW-1:0] rsum_q [NC][K];
  logic signed [AW-1:0]  tot_q [NC];
  logic [CHW-1:0]        och_q [NC];
  logic                  s4_last_q, olast_q;

  logic signed [AW-1:0]  bias_term, half;
  logic signed [AW-1:0]  scaled [NC];

  assign en    = !ov_q || res_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q     <= lbuf_q[col_i];
      s0_col_q <= col_i;
      s0_pix_q <= sample_i;
      s0_tag_q <= tag_i;
    end
    if (en && s0_v_q) begin
      lbuf_q[s0_col_q] <= {rd_q[(NL-1)*PW-1:0], s0_pix_q};
    end
  end

  // window: column K-1 is newest, row K-1 is the current line
  always_ff @(posedge clk_i) begin
    if (en && s0_v_q) begin
      for (int u = 0; u < K; u++) begin
        for (int v = 0; v < K - 1; v++) begin
          win_q[u][v] <= win_q[u][v+1];
        end
      end
      win_q[K-1][K-1] <= s0_pix_q;
      for (int i = 0; i < NL; i++) begin
        win_q[K-2-i][K-1] <= rd_q[i*PW +: PW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_tag_q <= s0_tag_q;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      for (int c = 0; c < NC; c++) begin
        for (int u = 0; u < K; u++) begin
          for (int v = 0; v < K; v++) begin
            if (s1_tag_q.rmask[u] && s1_tag_q.cmask[v]) begin
              prod_q[c][u][v] <= PRW'($signed(coef_i[u][v*CFW +: CFW])) *
                                 PRW'($signed({1'b0, win_q[u][v][c*CHW +: CHW]}));
            end else begin
              prod_q[c][u][v] <= '0;
            end
          end
        end
      end
      for (int c = 0; c < NC; c++) begin
        for (int u = 0; u < K; u++) begin
          rsum_q[c][u] <= RSW'(prod_q[c][u][0]) + RSW'(prod_q[c][u][1]) +
                          RSW'(prod_q[c][u][2]) + RSW'(prod_q[c][u][3]) +
                          RSW'(prod_q[c][u][4]);
        end
      end
      for (int c = 0; c < NC; c++) begin
        tot_q[c] <= AW'(rsum_q[c][0]) + AW'(rsum_q[c][1]) + AW'(rsum_q[c][2]) +
                    AW'(rsum_q[c][3]) + AW'(rsum_q[c][4]) + bias_term + half;
      end
      for (int c = 0; c < NC; c++) begin
        if (scaled[c] < 0) begin
          och_q[c] <= '0;
        end else if (scaled[c] > AW'(255)) begin
          och_q[c] <= '1;
        end else begin
          och_q[c] <= scaled[c][CHW-1:0];
        end
      end
      s4_last_q <= s3_tag_q.last;
      olast_q   <= s4_last_q;
    end
  end

  assign bias_term = AW'(bias_i) <<< shift_i;
  assign half      = (shift_i == '0) ? '0 : (AW'(1) <<< (shift_i - rcf_pkg::SHIFT_W'(1)));

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      scaled[c] = tot_q[c] >>> shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else if (en) begin
      s0_v_q <= !empty_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q && s3_tag_q.emit;
      ov_q   <= s4_v_q;
    end
  end

  assign res_o.valid      = ov_q;
  assign res_o.out_chan0  = och_q[0];
  assign res_o.out_chan1  = och_q[1];
  assign res_o.out_chan2  = och_q[2];
  assign res_o.frame_last = olast_q;

endmodule

>>> rtl/rgb_conv5x5_filter.sv
// Top level of the streaming RGB 5x5 convolution filter.
//
// Channels: pix_i takes raster-order pixel words (req_type 1 = zero pad),
// res_o gives filtered pixels, cfg_i writes the registers (index 0..4 kernel
// rows, 5 frac shift, 6 bias, 7 frame size). cfg_i is always ready.
// After each frame of width*height pixels the host sends 2*width+2 pad
// words; output pixel k leaves for input word k+2*width+2.
// Throughput: one word per clock while res_o takes results, set by the line
// store that is read at one column and written back at the previous column once per word.
// Path: a result reaches res_o from the word that causes it through the
// queue, store read, window, products, row sums, total and rounding
// registers.
// Reset: counters clear, registers take their default values, frame size
// is 640 x 480. Line store and window are not cleared; positions outside
// the frame are masked to zero.
// Stall: when res_o is not taken the back pipeline holds, the 4-word queue
// fills and then pix_i.ready drops.
module rgb_conv5x5_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rcf_pix_if.sink   pix_i,
  rcf_res_if.source res_o,
  rcf_cfg_if.sink   cfg_i
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int TW    = $bits(rcf_pkg::tag_t);
  localparam int QW    = CW + rcf_pkg::PIX_W + TW;
  localparam int QDEPTH = 4;

  logic [rcf_pkg::KSIZE-1:0][rcf_pkg::CFG_DATA_W-1:0] coef_q;
  logic [rcf_pkg::SHIFT_W-1:0]       shift_q;
  logic signed [rcf_pkg::BIAS_W-1:0] bias_q;
  logic [rcf_pkg::FSIZE_W-1:0]       fsize_q;

  logic                       push, pop, full, empty;
  logic [CW-1:0]              f_col, b_col;
  logic [rcf_pkg::PIX_W-1:0]  f_pix, b_pix;
  rcf_pkg::tag_t              f_tag, b_tag;
  logic [QW-1:0]              q_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= '0;
      shift_q <= '0;
      bias_q  <= '0;
      fsize_q <= rcf_pkg::FRAME_SIZE_RST;
    end else if (cfg_i.valid) begin
      case (rcf_pkg::cfg_reg_e'(cfg_i.index))
        rcf_pkg::REG_COEF0: coef_q[0] <= cfg_i.data;
        rcf_pkg::REG_COEF1: coef_q[1] <= cfg_i.data;
        rcf_pkg::REG_COEF2: coef_q[2] <= cfg_i.data;
        rcf_pkg::REG_COEF3: coef_q[3] <= cfg_i.data;
        rcf_pkg::REG_COEF4: coef_q[4] <= cfg_i.data;
        rcf_pkg::REG_SHIFT: shift_q   <= cfg_i.data[rcf_pkg::SHIFT_W-1:0];
        rcf_pkg::REG_BIAS:  bias_q    <= $signed(cfg_i.data[rcf_pkg::BIAS_W-1:0]);
        rcf_pkg::REG_FRAME: fsize_q   <= cfg_i.data[rcf_pkg::FSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  rcf_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .WW(WW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_size_i (fsize_q),
    .pix_i        (pix_i),
    .full_i       (full),
    .push_o       (push),
    .col_o        (f_col),
    .sample_o     (f_pix),
    .tag_o        (f_tag)
  );

  rcf_fifo #(.DW(QW), .DEPTH(QDEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_col, f_pix, f_tag}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign b_col = q_rdata[QW-1 -: CW];
  assign b_pix = q_rdata[TW +: rcf_pkg::PIX_W];
  assign b_tag = rcf_pkg::tag_t'(q_rdata[TW-1:0]);

  rcf_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef_q),
    .shift_i  (shift_q),
    .bias_i   (bias_q),
    .empty_i  (empty),
    .pop_o    (pop),
    .col_i    (b_col),
    .sample_i (b_pix),
    .tag_i    (b_tag),
    .res_o    (res_o)
  );

endmodule

>>> dv/tb_rgb_conv5x5_filter.sv
// Testbench of the RGB 5x5 convolution filter: frames in, checked against a local predictor.
module tb_rgb_conv5x5_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_W     = rcf_pkg::CHAN_W;
  localparam int CFG_DATA_W = rcf_pkg::CFG_DATA_W;
  localparam int KSIZE      = rcf_pkg::KSIZE;
  localparam int SHIFT_W    = rcf_pkg::SHIFT_W;
  localparam int BIAS_W     = rcf_pkg::BIAS_W;
  localparam int FSIZE_W    = rcf_pkg::FSIZE_W;
  localparam int PIX_W      = rcf_pkg::PIX_W;
  localparam int MIN_DIM    = rcf_pkg::MIN_DIM;
  localparam int NCHAN      = rcf_pkg::NCHAN;
  localparam int HALF_K     = rcf_pkg::HALF_K;
  localparam int COEF_W     = rcf_pkg::COEF_W;

  localparam int MAXW      = 1024;
  localparam int MAXH      = 4095;
  localparam int HIST_SIZE = 4 * MAXW + 8;
  localparam int IDLE_LIM  = 20000;
  localparam int RAND_WORDS = 900;

  typedef struct packed {
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic              last;
  } pix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rcf_pix_if pix ();
  rcf_res_if res ();
  rcf_cfg_if cfg ();

  rgb_conv5x5_filter #(.MAX_WIDTH(MAXW)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .res_o (res),
    .cfg_i (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block's registers and frame state
  logic [CFG_DATA_W-1:0]   kern_row [KSIZE];
  logic [SHIFT_W-1:0]      frac_sh;
  logic signed [BIAS_W-1:0] bias_r;
  logic [FSIZE_W-1:0]      fsize;
  logic [PIX_W-1:0]        hist [HIST_SIZE];
  int unsigned             col_in, row_in, out_idx, fw, fh;
  bit                      in_frame;

  pix_res_t filt_q[$];
  int       n_err;
  int       words_sent;
  int       idle_cnt;
  bit       no_gaps;
  int       hold_cnt;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    n_err++;
  endtask

  function automatic int unsigned clamp_dim(input int unsigned d, input int unsigned hi);
    if (d < MIN_DIM) return MIN_DIM;
    if (d > hi) return hi;
    return d;
  endfunction

  function automatic logic [CHAN_W-1:0] round_sat(input longint acc);
    longint v;
    longint half;
    half = (frac_sh == 0) ? 0 : (longint'(1) <<< (frac_sh - 1));
    v = acc + (longint'(bias_r) <<< frac_sh) + half;
    v = v >>> frac_sh;
    if (v < 0) return '0;
    if (v > 255) return 8'hff;
    return v[CHAN_W-1:0];
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < HIST_SIZE; i++) hist[i] = '0;
    col_in = 0;
    row_in = 0;
    out_idx = 0;
    in_frame = 0;
  endtask

  // one accepted pixel word: store it, emit the filtered pixel that it completes
  task automatic filter_word(input logic pad, input logic [PIX_W-1:0] smp);
    int unsigned pos, r, c;
    int rr, cc, kc;
    longint acc [NCHAN];
    logic [PIX_W-1:0] px;
    pix_res_t e;
    if (!in_frame) begin
      fw = clamp_dim(fsize[11:0], MAXW);
      fh = clamp_dim(fsize[23:12], MAXH);
      in_frame = 1;
    end
    pos = row_in * fw + col_in;
    hist[pos % HIST_SIZE] = pad ? '0 : smp;
    col_in++;
    if (col_in >= fw) begin
      col_in = 0;
      row_in++;
    end
    if (pos < 2 * fw + 2) return;
    r = out_idx / fw;
    c = out_idx % fw;
    for (int ch = 0; ch < NCHAN; ch++) acc[ch] = 0;
    for (int u = 0; u < KSIZE; u++) begin
      rr = int'(r) + u - HALF_K;
      if (rr < 0 || rr >= int'(fh)) continue;
      for (int v = 0; v < KSIZE; v++) begin
        cc = int'(c) + v - HALF_K;
        if (cc < 0 || cc >= int'(fw)) continue;
        kc = int'($signed(kern_row[u][COEF_W*v +: COEF_W]));
        px = hist[(rr * fw + cc) % HIST_SIZE];
        for (int ch = 0; ch < NCHAN; ch++)
          acc[ch] += longint'(kc) * longint'(px[CHAN_W*ch +: CHAN_W]);
      end
    end
    e.c0 = round_sat(acc[0]);
    e.c1 = round_sat(acc[1]);
    e.c2 = round_sat(acc[2]);
    e.last = (out_idx + 1 >= fw * fh);
    filt_q.push_back(e);
    if (e.last) clear_frame();
    else out_idx++;
  endtask

  // predictor and register mirror follow the accepted words
  always @(posedge clk_i) begin
    if (rst_ni && cfg.valid && cfg.ready) begin
      case (rcf_pkg::cfg_reg_e'(cfg.index))
        rcf_pkg::REG_COEF0, rcf_pkg::REG_COEF1, rcf_pkg::REG_COEF2,
        rcf_pkg::REG_COEF3, rcf_pkg::REG_COEF4:
          kern_row[cfg.index] = cfg.data;
        rcf_pkg::REG_SHIFT: frac_sh = cfg.data[SHIFT_W-1:0];
        rcf_pkg::REG_BIAS:  bias_r  = cfg.data[BIAS_W-1:0];
        rcf_pkg::REG_FRAME: fsize   = cfg.data[FSIZE_W-1:0];
        default: ;
      endcase
    end
    if (rst_ni && pix.valid && pix.ready)
      filter_word(pix.req_type, {pix.chan2, pix.chan1, pix.chan0});
  end

  // result checker
  always @(posedge clk_i) begin
    pix_res_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (filt_q.size() == 0) begin
        report("result word with none expected");
      end else begin
        e = filt_q.pop_front();
        if (res.out_chan0 !== e.c0)
          report($sformatf("out_chan0 %0d exp %0d", res.out_chan0, e.c0));
        if (res.out_chan1 !== e.c1)
          report($sformatf("out_chan1 %0d exp %0d", res.out_chan1, e.c1));
        if (res.out_chan2 !== e.c2)
          report($sformatf("out_chan2 %0d exp %0d", res.out_chan2, e.c2));
        if (res.frame_last !== e.last)
          report($sformatf("frame_last %0b exp %0b", res.frame_last, e.last));
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    int p;
    if (!rst_ni) begin
      res.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      res.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      p = $urandom_range(0, 99);
      if (no_gaps || p < 70) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b0;
        hold_cnt <= (p < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIM) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic sender_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 70) return;
    pix.valid <= 1'b0;
    repeat ((p < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk_i);
  endtask

  task automatic send_word(input logic pad, input logic [CHAN_W-1:0] c0, c1, c2);
    sender_gap();
    pix.valid    <= 1'b1;
    pix.req_type <= pad;
    pix.chan0    <= c0;
    pix.chan1    <= c1;
    pix.chan2    <= c2;
    do @(posedge clk_i); while (!pix.ready);
    words_sent++;
  endtask

  task automatic write_reg(input rcf_pkg::cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] flat_row(input logic [COEF_W-1:0] k);
    return {KSIZE{k}};
  endfunction

  task automatic set_kernel(input logic [CFG_DATA_W-1:0] r0, r1, r2, r3, r4,
                            input logic [SHIFT_W-1:0] sh, input logic [BIAS_W-1:0] b);
    write_reg(rcf_pkg::REG_COEF0, r0);
    write_reg(rcf_pkg::REG_COEF1, r1);
    write_reg(rcf_pkg::REG_COEF2, r2);
    write_reg(rcf_pkg::REG_COEF3, r3);
    write_reg(rcf_pkg::REG_COEF4, r4);
    write_reg(rcf_pkg::REG_SHIFT, CFG_DATA_W'(sh));
    write_reg(rcf_pkg::REG_BIAS, CFG_DATA_W'(b));
  endtask

  // one frame plus its flush; pad_pct: pad words inside the image,
  // noise_pct: pixel words during the flush, which must be ignored
  task automatic run_frame(input int unsigned w_req, h_req, pad_pct, noise_pct,
                           input int mode);
    int unsigned w, h;
    logic [CHAN_W-1:0] c0, c1, c2;
    write_reg(rcf_pkg::REG_FRAME, CFG_DATA_W'({h_req[11:0], w_req[11:0]}));
    w = clamp_dim(w_req, MAXW);
    h = clamp_dim(h_req, MAXH);
    for (int i = 0; i < w * h; i++) begin
      case (mode)
        0: begin
          c0 = CHAN_W'($urandom);
          c1 = CHAN_W'($urandom);
          c2 = CHAN_W'($urandom);
        end
        1: begin c0 = (i % 2) ? 8'hff : 8'h00; c1 = ~c0; c2 = i[7:0]; end
        default: begin c0 = 8'hff; c1 = 8'hff; c2 = 8'hff; end
      endcase
      send_word($urandom_range(0, 99) < pad_pct, c0, c1, c2);
    end
    for (int i = 0; i < 2 * w + 2; i++)
      if ($urandom_range(0, 99) < noise_pct)
        send_word(1'b0, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
      else
        send_word(1'b1, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    drain();
  endtask

  // identity kernel, extreme pixels, pad inside image, pixels during flush
  task automatic test_identity();
    set_kernel('0, '0, CFG_DATA_W'(1) << (COEF_W * 2), '0, '0, 4'd0, 9'd0);
    run_frame(5, 5, 20, 50, 1);
  endtask

  task automatic test_saturation();
    set_kernel(flat_row(12'h7ff), flat_row(12'h7ff), flat_row(12'h7ff),
               flat_row(12'h7ff), flat_row(12'h7ff), 4'd0, 9'h0ff);
    run_frame(5, 5, 0, 0, 2);
    set_kernel(flat_row(12'h800), flat_row(12'h800), flat_row(12'h800),
               flat_row(12'h800), flat_row(12'h800), 4'd0, 9'h100);
    run_frame(6, 5, 0, 0, 2);
  endtask

  // deepest shift and odd coefficients put ties on the rounding step
  task automatic test_rounding();
    set_kernel(flat_row(12'h001), flat_row(12'hfff), flat_row(12'h003),
               flat_row(12'h7ff), flat_row(12'h800), 4'd15, 9'h1ff);
    run_frame(5, 6, 10, 10, 0);
    set_kernel(flat_row(12'h080), flat_row(12'h080), flat_row(12'h080),
               flat_row(12'h080), flat_row(12'h081), 4'd8, 9'd3);
    run_frame(7, 5, 0, 0, 0);
  endtask

  // undersized frame sizes clamp to the minimum dimension
  task automatic test_size_clamp();
    run_frame(0, 0, 5, 5, 0);
    no_gaps = 1;
    run_frame(13, 1, 0, 0, 0);
    no_gaps = 0;
    run_frame(4, 4095 - 4090, 0, 0, 0);
  endtask

  task automatic test_random();
    logic [CFG_DATA_W-1:0] r [KSIZE];
    while (words_sent < RAND_WORDS) begin
      for (int u = 0; u < KSIZE; u++)
        for (int v = 0; v < KSIZE; v++)
          r[u][COEF_W*v +: COEF_W] = ($urandom_range(0, 3) == 0) ?
            COEF_W'($urandom) : COEF_W'($urandom_range(0, 64) - 32);
      set_kernel(r[0], r[1], r[2], r[3], r[4], SHIFT_W'($urandom_range(0, 15)),
                 BIAS_W'($urandom));
      no_gaps = ($urandom_range(0, 3) == 0);
      run_frame($urandom_range(5, 12), $urandom_range(5, 8),
                $urandom_range(0, 10), $urandom_range(0, 10), 0);
    end
    no_gaps = 0;
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.req_type = 1'b0;
    pix.chan0 = '0;
    pix.chan1 = '0;
    pix.chan2 = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    res.ready = 1'b0;
    for (int u = 0; u < KSIZE; u++) kern_row[u] = '0;
    frac_sh = '0;
    bias_r = '0;
    fsize = rcf_pkg::FRAME_SIZE_RST;
    n_err = 0;
    words_sent = 0;
    idle_cnt = 0;
    no_gaps = 0;
    clear_frame();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity();
    test_saturation();
    test_rounding();
    test_size_clamp();
    test_random();
    drain();
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rcf_pkg.sv
rtl/rcf_if.sv
rtl/rcf_front.sv
rtl/rcf_fifo.sv
rtl/rcf_back.sv
rtl/rgb_conv5x5_filter.sv
dv/tb_rgb_conv5x5_filter.sv
